/* hw/rtl/cda_pkg.sv */
`timescale 1ns / 1ps
package cda_pkg;

	localparam int YEAR_MAX = 9999;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 23;
	localparam int ST_W   = 2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_A = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_B = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	localparam logic FUNC_DIFF = 1'b0;
	localparam logic FUNC_ADD  = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	localparam longint unsigned ERA_DAYS = 64'd146097;

	// reciprocals for division by constants
	localparam int K_Y100 = 21;
	localparam longint unsigned M_Y100 = ((64'd1 << K_Y100) + 64'd99) / 64'd100;
	localparam int K_Y400 = 23;
	localparam longint unsigned M_Y400 = ((64'd1 << K_Y400) + 64'd399) / 64'd400;
	localparam int K_ERA = 41;
	localparam longint unsigned M_ERA = (64'd1 << K_ERA) / ERA_DAYS;
	localparam int K_1460 = 28;
	localparam longint unsigned M_1460 = ((64'd1 << K_1460) + 64'd1459) / 64'd1460;
	localparam int K_36524 = 33;
	localparam longint unsigned M_36524 = ((64'd1 << K_36524) + 64'd36523) / 64'd36524;
	localparam int K_365 = 26;
	localparam longint unsigned M_365 = ((64'd1 << K_365) + 64'd364) / 64'd365;
	localparam int K_C100 = 12;
	localparam longint unsigned M_C100 = ((64'd1 << K_C100) + 64'd99) / 64'd100;
	localparam int K_153 = 19;
	localparam longint unsigned M_153 = ((64'd1 << K_153) + 64'd152) / 64'd153;

	typedef struct packed {
		logic              func;
		logic [ST_W-1:0]   st;
		logic [CNT_W-1:0]  days_a;
		logic [CNT_W-1:0]  days_b;
		logic signed [CNT_W-1:0] ofs;
	} q_entry_t;

	// first day of each month counted from March
	function automatic logic [8:0] mp_offset(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/cda_in_if.sv */
`timescale 1ns / 1ps
interface cda_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [cda_pkg::DAY_W-1:0]  day_a;
	logic [cda_pkg::MON_W-1:0]  month_a;
	logic [cda_pkg::YEAR_W-1:0] year_a;
	logic [cda_pkg::DAY_W-1:0]  day_b;
	logic [cda_pkg::MON_W-1:0]  month_b;
	logic [cda_pkg::YEAR_W-1:0] year_b;
	logic signed [cda_pkg::CNT_W-1:0] day_offset;

	modport source (output valid, func, day_a, month_a, year_a, day_b, month_b, year_b,
		day_offset, input ready);
	modport sink (input valid, func, day_a, month_a, year_a, day_b, month_b, year_b,
		day_offset, output ready);
endinterface

/* hw/rtl/cda_out_if.sv */
`timescale 1ns / 1ps
interface cda_out_if;
	logic                       valid;
	logic                       ready;
	logic [cda_pkg::DAY_W-1:0]  result_day;
	logic [cda_pkg::MON_W-1:0]  result_month;
	logic [cda_pkg::YEAR_W-1:0] result_year;
	logic signed [cda_pkg::CNT_W-1:0] day_count;
	logic [cda_pkg::ST_W-1:0]   status;

	modport source (output valid, result_day, result_month, result_year, day_count, status,
		input ready);
	modport sink (input valid, result_day, result_month, result_year, day_count, status,
		output ready);
endinterface

/* hw/rtl/calendar_date_arithmetic.sv */
// channel  dir  handshake      payload
// req      in   valid/ready    func, dates A and B, day_offset
// rsp      out  valid/ready    result date, day_count, status
//
// One request per cycle sustained while responses are taken; accepted requests pass
// through the queue and then the nine-stage back pipeline, which turns a day count
// into a date through chained reciprocal multiplies.
// Reset clears the queue and all stage valid bits; no clearing pass.
// A stalled response freezes the back pipeline; the two-entry queue keeps
// accepting requests until it is full.
`timescale 1ns / 1ps
module calendar_date_arithmetic (
	input  logic      clk,
	input  logic      arst_n,
	cda_in_if.sink    req,
	cda_out_if.source rsp
);
	import cda_pkg::*;

	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic             push;
	logic             pop;
	logic             q_valid;
	logic             full;
	q_entry_t         wdata;
	q_entry_t         rdata;
	logic [LVL_W-1:0] level;

	cda_front u_front (
		.req   (req),
		.full  (full),
		.push  (push),
		.entry (wdata)
	);

	cda_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (wdata),
		.pop     (pop),
		.q_valid (q_valid),
		.full    (full),
		.rdata   (rdata),
		.level   (level)
	);

	cda_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (rdata),
		.pop     (pop),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.result_day == '0 && rsp.result_month == '0
			&& rsp.result_year == '0 && rsp.day_count == '0)
		else $error("failed response carries nonzero fields");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_OK && rsp.result_month != '0 |-> rsp.day_count == '0)
		else $error("add response carries a day count");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> level == $past(level) + LVL_W'(1))
		else $error("queue level did not advance on push");
`endif
endmodule

/* hw/rtl/cda_front.sv */
`timescale 1ns / 1ps
module cda_front (
	cda_in_if.sink             req,
	input  logic               full,
	output logic               push,
	output cda_pkg::q_entry_t  entry
);
	import cda_pkg::*;

	function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		logic [28:0] p100;
		logic [7:0]  q100;
		logic [YEAR_W-1:0] rem100;
		logic leap;
		logic [DAY_W-1:0] last;
		p100   = {15'd0, y} * 29'(M_Y100);
		q100   = p100[K_Y100+7:K_Y100];
		rem100 = y - YEAR_W'({q100, 6'd0} + {q100, 5'd0} + {q100, 2'd0});
		leap   = ((y[1:0] == 2'd0) && (rem100 != '0)) || ((rem100 == '0) && (q100[1:0] == 2'd0));
		case (m)
			4'd2:                      last = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   last = 5'd30;
			default:                   last = 5'd31;
		endcase
		return (y >= YEAR_W'(1)) && (y <= YEAR_W'(YEAR_MAX)) && (m >= 4'd1) && (m <= 4'd12)
			&& (d >= 5'd1) && (d <= last);
	endfunction

	function automatic logic [CNT_W-1:0] to_days(input logic [DAY_W-1:0] d,
		input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] yy;
		logic [28:0] p100;
		logic [28:0] p400;
		logic [3:0]  mp;
		logic [23:0] days;
		yy   = (m <= 4'd2) ? y - YEAR_W'(1) : y;
		p100 = {15'd0, yy} * 29'(M_Y100);
		p400 = {15'd0, yy} * 29'(M_Y400);
		mp   = (m >= 4'd3) ? m - 4'd3 : m + 4'd9;
		days = 24'(yy) * 24'd365 + 24'(yy[YEAR_W-1:2]) - 24'(p100[K_Y100+7:K_Y100])
			+ 24'(p400[K_Y400+5:K_Y400]) + 24'(mp_offset(mp)) + 24'(d) - 24'd1;
		return days[CNT_W-1:0];
	endfunction

	logic ok_a;
	logic ok_b;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		ok_a         = date_ok(req.day_a, req.month_a, req.year_a);
		ok_b         = date_ok(req.day_b, req.month_b, req.year_b);
		entry.func   = req.func;
		entry.days_a = to_days(req.day_a, req.month_a, req.year_a);
		entry.days_b = to_days(req.day_b, req.month_b, req.year_b);
		entry.ofs    = req.day_offset;
		if (!ok_a) begin
			entry.st = ST_BAD_A;
		end else if (req.func == FUNC_DIFF && !ok_b) begin
			entry.st = ST_BAD_B;
		end else begin
			entry.st = ST_OK;
		end
	end
endmodule

/* hw/rtl/cda_queue.sv */
`timescale 1ns / 1ps
module cda_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cda_pkg::q_entry_t  wdata,
	input  logic               pop,
	output logic               q_valid,
	output logic               full,
	output cda_pkg::q_entry_t  rdata,
	output logic [$clog2(cda_pkg::QUEUE_DEPTH+1)-1:0] level
);
	import cda_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [LVL_W-1:0]  cnt_q;

	assign q_valid = (cnt_q != '0);
	assign full    = (cnt_q == LVL_W'(QUEUE_DEPTH));
	assign rdata   = mem_q[rd_q];
	assign level   = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + LVL_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - LVL_W'(1);
			end
		end
	end
endmodule

/* hw/rtl/cda_back.sv */
`timescale 1ns / 1ps
module cda_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cda_pkg::q_entry_t  q_data,
	output logic               pop,
	cda_out_if.source          rsp
);
	import cda_pkg::*;

	localparam int NSTG = 9;

	logic [NSTG-1:0] vld_q;
	logic            adv;

	logic              func_s1;
	logic [ST_W-1:0]   st_s1;
	logic [23:0]       diff_s1;
	logic [24:0]       z_s1;

	logic [ST_W-1:0]   st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	logic [CNT_W-1:0]  cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6, cnt_s7, cnt_s8;
	logic              add_s2, add_s3, add_s4, add_s5, add_s6, add_s7, add_s8;
	logic [23:0]       zu_s2, zu_s3;
	logic [47:0]       pe_s2;
	logic [6:0]        era_s3, era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [24:0]       ep_s3;
	logic [17:0]       doe_s4, doe_s5, doe_s6, doe_s7;
	logic [6:0]        a_s5;
	logic [2:0]        b_s5;
	logic              c_s5;
	logic [17:0]       n_s6;
	logic [8:0]        yoe_s7, yoe_s8;
	logic [8:0]        doy_s8;

	logic [DAY_W-1:0]  day_s9;
	logic [MON_W-1:0]  mon_s9;
	logic [YEAR_W-1:0] year_s9;
	logic [CNT_W-1:0]  cnt_s9;
	logic [ST_W-1:0]   st_s9;

	logic [ST_W-1:0]   st2;
	logic [24:0]       r4;
	logic [35:0]       pa5;
	logic [35:0]       pb5;
	logic [35:0]       pn7;
	logic [17:0]       t8;
	logic [10:0]       x9;
	logic [22:0]       p9;
	logic [3:0]        mp9;
	logic [8:0]        d9;
	logic [MON_W-1:0]  m9;
	logic [15:0]       yy9;
	logic [15:0]       y9;
	logic              ok9;

	assign adv = !vld_q[NSTG-1] || rsp.ready;
	assign pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], q_valid};
		end
	end

	always_comb begin
		st2 = st_s1;
		if (st_s1 == ST_OK) begin
			if (func_s1 == FUNC_DIFF) begin
				if (diff_s1[23] != diff_s1[22]) begin
					st2 = ST_RANGE;
				end
			end else if (z_s1[24]) begin
				st2 = ST_RANGE;
			end
		end
		r4  = {1'b0, zu_s3} - ep_s3;
		pa5 = {18'd0, doe_s4} * 36'(M_1460);
		pb5 = {18'd0, doe_s4} * 36'(M_36524);
		pn7 = {18'd0, n_s6} * 36'(M_365);
		t8  = 18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2])
			- 18'((14'(yoe_s7) * 14'(M_C100)) >> K_C100);
		x9  = 11'(doy_s8) * 11'd5 + 11'd2;
		p9  = 23'(x9) * 23'(M_153);
		mp9 = p9[K_153+3:K_153];
		d9  = doy_s8 - mp_offset(mp9) + 9'd1;
		m9  = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;
		yy9 = 16'(yoe_s8) + 16'(era_s8) * 16'd400;
		y9  = (m9 <= 4'd2) ? yy9 + 16'd1 : yy9;
		ok9 = add_s8 && (y9 >= 16'd1) && (y9 <= 16'(YEAR_MAX));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= q_data.func;
			st_s1   <= q_data.st;
			diff_s1 <= {1'b0, q_data.days_a} - {1'b0, q_data.days_b};
			z_s1    <= {2'b0, q_data.days_a} + {{2{q_data.ofs[CNT_W-1]}}, q_data.ofs};

			st_s2  <= st2;
			cnt_s2 <= (st2 == ST_OK && func_s1 == FUNC_DIFF) ? diff_s1[CNT_W-1:0] : '0;
			add_s2 <= (st2 == ST_OK && func_s1 == FUNC_ADD);
			zu_s2  <= z_s1[23:0];
			pe_s2  <= {24'd0, z_s1[23:0]} * 48'(M_ERA);

			st_s3  <= st_s2;
			cnt_s3 <= cnt_s2;
			add_s3 <= add_s2;
			zu_s3  <= zu_s2;
			era_s3 <= pe_s2[K_ERA+6:K_ERA];
			ep_s3  <= 25'(pe_s2[K_ERA+6:K_ERA]) * 25'(ERA_DAYS);

			st_s4  <= st_s3;
			cnt_s4 <= cnt_s3;
			add_s4 <= add_s3;
			if (r4 >= 25'(ERA_DAYS)) begin
				era_s4 <= era_s3 + 7'd1;
				doe_s4 <= 18'(r4 - 25'(ERA_DAYS));
			end else begin
				era_s4 <= era_s3;
				doe_s4 <= r4[17:0];
			end

			st_s5  <= st_s4;
			cnt_s5 <= cnt_s4;
			add_s5 <= add_s4;
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			a_s5   <= pa5[K_1460+6:K_1460];
			b_s5   <= pb5[K_36524+2:K_36524];
			c_s5   <= (doe_s4 == 18'(ERA_DAYS - 64'd1));

			st_s6  <= st_s5;
			cnt_s6 <= cnt_s5;
			add_s6 <= add_s5;
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			n_s6   <= doe_s5 + 18'(b_s5) - 18'(a_s5) - 18'(c_s5);

			st_s7  <= st_s6;
			cnt_s7 <= cnt_s6;
			add_s7 <= add_s6;
			era_s7 <= era_s6;
			doe_s7 <= doe_s6;
			yoe_s7 <= pn7[K_365+8:K_365];

			st_s8  <= st_s7;
			cnt_s8 <= cnt_s7;
			add_s8 <= add_s7;
			era_s8 <= era_s7;
			yoe_s8 <= yoe_s7;
			doy_s8 <= 9'(doe_s7 - t8);

			day_s9  <= ok9 ? d9[DAY_W-1:0] : '0;
			mon_s9  <= ok9 ? m9 : '0;
			year_s9 <= ok9 ? y9[YEAR_W-1:0] : '0;
			cnt_s9  <= cnt_s8;
			st_s9   <= (add_s8 && !ok9) ? ST_RANGE : st_s8;
		end
	end

	assign rsp.valid        = vld_q[NSTG-1];
	assign rsp.result_day   = day_s9;
	assign rsp.result_month = mon_s9;
	assign rsp.result_year  = year_s9;
	assign rsp.day_count    = cnt_s9;
	assign rsp.status       = st_s9;
endmodule

/* verif/calendar_date_arithmetic_checker.sv */
`timescale 1ns / 1ps
module calendar_date_arithmetic_checker (
	input  logic    clk,
	input  logic    arst_n,
	cda_in_if.sink  req,
	cda_out_if.sink rsp,
	output int      fail_count,
	output int      pending_count
);
	import cda_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [CNT_W-1:0]  count;
		logic [ST_W-1:0]   status;
	} date_result_t;

	date_result_t expected_results[$];

	function automatic bit is_leap(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic bit date_valid(longint d, longint m, longint y);
		longint last;
		if (y < 1 || y > YEAR_MAX || m < 1 || m > 12 || d < 1)
			return 0;
		if (m == 2)
			last = is_leap(y) ? 29 : 28;
		else if (m == 4 || m == 6 || m == 9 || m == 11)
			last = 30;
		else
			last = 31;
		return d <= last;
	endfunction

	function automatic longint day_number(longint d, longint m, longint y);
		longint yy, era, yoe, mp, doy;
		yy = (m <= 2) ? y - 1 : y;
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m + 9) % 12;
		doy = (153 * mp + 2) / 5 + d - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic date_result_t compute_date_op(
		logic func, longint da, longint ma, longint ya,
		longint db, longint mb, longint yb, longint ofs);
		date_result_t r;
		longint diff, z, era, doe, yoe, doy, mp, d, m, y;
		r = '0;
		if (!date_valid(da, ma, ya)) begin
			r.status = ST_BAD_A;
		end else if (func == FUNC_DIFF) begin
			if (!date_valid(db, mb, yb)) begin
				r.status = ST_BAD_B;
			end else begin
				diff = day_number(da, ma, ya) - day_number(db, mb, yb);
				if (diff < -4194304 || diff > 4194303)
					r.status = ST_RANGE;
				else
					r.count = diff[CNT_W-1:0];
			end
		end else begin
			z = day_number(da, ma, ya) + ofs;
			if (z < 0) begin
				r.status = ST_RANGE;
			end else begin
				era = z / 146097;
				doe = z - era * 146097;
				yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
				doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
				mp = (5 * doy + 2) / 153;
				d = doy - (153 * mp + 2) / 5 + 1;
				m = (mp < 10) ? mp + 3 : mp - 9;
				y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
				if (y < 1 || y > YEAR_MAX) begin
					r.status = ST_RANGE;
				end else begin
					r.day = d[DAY_W-1:0];
					r.month = m[MON_W-1:0];
					r.year = y[YEAR_W-1:0];
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		date_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_results.push_back(compute_date_op(req.func, req.day_a,
					req.month_a, req.year_a, req.day_b, req.month_b, req.year_b,
					longint'(req.day_offset)));
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected response", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_day !== want.day)
						report_mismatch("result_day", rsp.result_day, want.day);
					if (rsp.result_month !== want.month)
						report_mismatch("result_month", rsp.result_month, want.month);
					if (rsp.result_year !== want.year)
						report_mismatch("result_year", rsp.result_year, want.year);
					if (rsp.day_count !== want.count)
						report_mismatch("day_count", rsp.day_count,
							$signed(want.count));
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
				end
			end
		end
		pending_count = expected_results.size();
	end
endmodule

/* verif/calendar_date_arithmetic_test.sv */
`timescale 1ns / 1ps
module calendar_date_arithmetic_test;
	import cda_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   cycle_count;

	cda_in_if  req();
	cda_out_if rsp();

	calendar_date_arithmetic u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	calendar_date_arithmetic_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending_count(pending_count));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// hold ready low for a random number of cycles per response
	initial begin
		int wait_cycles;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (wait_cycles > 0) begin
				rsp.ready <= 0;
				repeat (wait_cycles) @(negedge clk);
			end
			rsp.ready <= 1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	task automatic send_request(logic func, int da, int ma, int ya, int db, int mb,
		int yb, int ofs, bit no_gap);
		int wait_cycles;
		wait_cycles = no_gap ? 0 : $urandom_range(0, 16);
		if (wait_cycles > 0) begin
			req.valid <= 0;
			repeat (wait_cycles) @(negedge clk);
		end
		req.valid <= 1;
		req.func <= func;
		req.day_a <= DAY_W'(da);
		req.month_a <= MON_W'(ma);
		req.year_a <= YEAR_W'(ya);
		req.day_b <= DAY_W'(db);
		req.month_b <= MON_W'(mb);
		req.year_b <= YEAR_W'(yb);
		req.day_offset <= CNT_W'(ofs);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int rand_year();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 16383);
			1: return $urandom_range(1, 3);
			2: return $urandom_range(YEAR_MAX - 2, YEAR_MAX);
			3: return 400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100;
			default: return $urandom_range(1, YEAR_MAX);
		endcase
	endfunction

	function automatic int rand_day();
		return $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 31);
	endfunction

	function automatic int rand_month();
		return $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 12);
	endfunction

	function automatic int rand_offset();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 8388607) - 4194304);
			1: return $signed($urandom_range(0, 2000)) - 1000;
			2: return $urandom_range(0, 1) ? 4194303 : -4194304;
			default: return $signed($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	initial begin
		bit burst;
		arst_n = 0;
		req.valid = 0;
		req.func = FUNC_DIFF;
		req.day_a = '0;
		req.month_a = '0;
		req.year_a = '0;
		req.day_b = '0;
		req.month_b = '0;
		req.year_b = '0;
		req.day_offset = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_request(FUNC_DIFF, 1, 1, 1, 1, 1, 1, 0, 0);
		send_request(FUNC_DIFF, 31, 12, YEAR_MAX, 1, 1, 1, 0, 0);
		send_request(FUNC_DIFF, 1, 1, 1, 31, 12, YEAR_MAX, 0, 0);
		send_request(FUNC_DIFF, 29, 2, 2000, 28, 2, 1900, 0, 0);
		send_request(FUNC_DIFF, 29, 2, 1900, 1, 1, 2000, 0, 0);
		send_request(FUNC_DIFF, 0, 0, 0, 0, 0, 0, 4194303, 0);
		send_request(FUNC_DIFF, 1, 3, 2004, 31, 4, 2004, 0, 0);
		send_request(FUNC_DIFF, 31, 15, 16383, 31, 15, 16383, -4194304, 0);
		send_request(FUNC_DIFF, 1, 1, 10000, 1, 1, 1, 0, 0);
		send_request(FUNC_ADD, 1, 1, 1, 0, 0, 0, -1, 0);
		send_request(FUNC_ADD, 31, 12, YEAR_MAX, 31, 15, 16383, 1, 0);
		send_request(FUNC_ADD, 28, 2, 2000, 0, 0, 0, 1, 0);
		send_request(FUNC_ADD, 28, 2, 2100, 0, 0, 0, 1, 0);
		send_request(FUNC_ADD, 1, 1, 1, 0, 0, 0, 4194303, 0);
		send_request(FUNC_ADD, 31, 12, YEAR_MAX, 0, 0, 0, -4194304, 0);
		send_request(FUNC_ADD, 1, 1, 5000, 0, 0, 0, 0, 0);
		send_request(FUNC_ADD, 31, 6, 2023, 0, 0, 0, 5, 0);
		send_request(FUNC_ADD, 15, 6, 2023, 0, 0, 0, -4194304, 0);

		// pause until all responses have drained
		req.valid <= 0;
		while (pending_count != 0) @(negedge clk);

		for (int i = 0; i < 1250; i++) begin
			if (i % 50 == 0)
				burst = $urandom_range(0, 2) == 0;
			send_request(1'($urandom_range(0, 1)), rand_day(), rand_month(), rand_year(),
				rand_day(), rand_month(), rand_year(), rand_offset(), burst);
		end
		req.valid <= 0;

		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
